FILE: rtl/nss_pkg.sv
// Package for the 3x3 neighbour sum unit: shared constants, control structs,
// operation codes and the back-end sequencer states.
// No dependencies.
`timescale 1ns / 1ps

package nss_pkg;

    localparam int MAX_GRID_DEF  = 32;
    localparam int CELL_BITS_DEF = 8;
    localparam int SUM_W         = 11;
    localparam int GRID_W        = 6;
    localparam logic [GRID_W-1:0] GRID_RESET = GRID_W'(32);

    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;

    localparam int QUEUE_DEPTH = 4;
    localparam int OUT_DEPTH   = 4;

    // Register index, taken from paddr[2].
    localparam logic REG_GRID_SIZE = 1'b0;

    // Classification of one accepted cell, made by the front end.
    typedef struct packed {
        logic up_v;      // row two above holds data of this grid
        logic mid_v;     // row above holds data of this grid
        logic emit;      // this cell completes the window of the upper-left cell
        logic extra;     // last column: the cell above is completed as well
        logic is_final;  // final cell of the grid: the last row is flushed
    } t_item_flags;

    typedef enum logic [1:0] {
        OP_CELL,
        OP_ZERO,
        OP_FLUSH
    } t_op_kind;

    typedef struct packed {
        logic up_v;
        logic mid_v;
        logic clear;
        logic emit;
        logic last;
        logic eog;
    } t_op_ctl;

    typedef enum logic [1:0] {
        SEQ_ITEM,
        SEQ_EXTRA,
        SEQ_FLUSH,
        SEQ_TAIL
    } t_seq_state;

    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic             last_of_run;
        logic             end_of_grid;
    } t_result;

endpackage

FILE: rtl/nss_fifo.sv
// Small register-based FIFO used for the work queue and the result buffer.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps

module nss_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4,
    localparam int AW = $clog2(DEPTH),
    localparam int CW = $clog2(DEPTH + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty,
    output logic             o_full,
    output logic [CW-1:0]    o_count
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wptr;
    logic [AW-1:0]    r_rptr;
    logic [CW-1:0]    r_count;
    logic             do_push;
    logic             do_pop;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CW'(DEPTH));
    assign o_count = r_count;
    assign o_data  = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == AW'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == AW'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

endmodule

FILE: rtl/nss_front.sv
// Front end: accepts cells, tracks the raster position and classifies each cell
// for the back end. Depends on nss_pkg.
`timescale 1ns / 1ps

module nss_front #(
    parameter int MAX_GRID = nss_pkg::MAX_GRID_DEF,
    localparam int COL_W = $clog2(MAX_GRID)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic                 i_queue_full,
    input  logic                 i_restart,
    input  logic [COL_W-1:0]     i_last,
    output logic                 o_stall,
    output logic                 o_push,
    output logic [COL_W-1:0]     o_col,
    output nss_pkg::t_item_flags o_flags
);

    logic [COL_W-1:0] r_row;
    logic [COL_W-1:0] r_col;
    logic             at_last_col;
    logic             at_last_row;

    assign o_stall     = i_queue_full;
    assign o_push      = i_valid && !i_queue_full;
    assign o_col       = r_col;
    assign at_last_col = (r_col == i_last);
    assign at_last_row = (r_row == i_last);

    always_comb begin
        o_flags.up_v     = (r_row > COL_W'(1));
        o_flags.mid_v    = (r_row != '0);
        o_flags.emit     = (r_row != '0) && (r_col != '0);
        o_flags.extra    = (r_row != '0) && at_last_col;
        o_flags.is_final = at_last_row && at_last_col;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
        end else if (i_restart) begin
            r_row <= '0;
            r_col <= '0;
        end else if (o_push) begin
            if (at_last_col) begin
                r_col <= '0;
                r_row <= at_last_row ? '0 : r_row + 1'b1;
            end else begin
                r_col <= r_col + 1'b1;
            end
        end
    end

endmodule

FILE: rtl/nss_back.sv
// Back end: sequences column operations from the queue, keeps the two previous
// rows in a line memory, slides a 3x3 window and sums all but its centre. Depends on nss_pkg.
`timescale 1ns / 1ps

module nss_back #(
    parameter int MAX_GRID  = nss_pkg::MAX_GRID_DEF,
    parameter int CELL_BITS = nss_pkg::CELL_BITS_DEF,
    parameter int OUT_DEPTH = nss_pkg::OUT_DEPTH,
    localparam int COL_W = $clog2(MAX_GRID),
    localparam int CW    = $clog2(OUT_DEPTH + 1)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_q_empty,
    input  logic [CELL_BITS-1:0] i_q_cell,
    input  logic [COL_W-1:0]     i_q_col,
    input  nss_pkg::t_item_flags i_q_flags,
    output logic                 o_q_pop,
    input  logic [COL_W-1:0]     i_last,
    input  logic [CW-1:0]        i_out_count,
    output logic                 o_push,
    output nss_pkg::t_result     o_result
);

    localparam int IW    = CW + 1;
    localparam int ACC_W = (CELL_BITS + 3 > nss_pkg::SUM_W) ? CELL_BITS + 3 : nss_pkg::SUM_W;

    nss_pkg::t_seq_state r_state, n_state;
    logic [COL_W-1:0]    r_j, n_j;
    logic                r_final, n_final;

    logic                op_valid;
    nss_pkg::t_op_kind   op_kind;
    logic [COL_W-1:0]    op_col;
    nss_pkg::t_op_ctl    op_ctl;

    logic                r_p1_valid;
    nss_pkg::t_op_kind   r_p1_kind;
    logic [COL_W-1:0]    r_p1_col;
    logic [CELL_BITS-1:0] r_p1_cell;
    nss_pkg::t_op_ctl    r_p1_ctl;
    logic [2*CELL_BITS-1:0] r_rd;

    logic                r_p2_valid;
    logic                r_p2_last;
    logic                r_p2_eog;

    // Each line entry holds {row two above, row above} for its column.
    logic [2*CELL_BITS-1:0] r_line [MAX_GRID];

    logic [CELL_BITS-1:0] rd_older, rd_newer;
    logic [CELL_BITS-1:0] col_u, col_m, col_l;
    logic [CELL_BITS-1:0] r_wu [3];
    logic [CELL_BITS-1:0] r_wm [3];
    logic [CELL_BITS-1:0] r_wl [3];
    logic [ACC_W-1:0]     acc;

    logic [IW-1:0]        inflight;
    logic                 credit;

    // A result is only started when the result buffer is sure to have room.
    assign inflight = IW'(i_out_count) + IW'(r_p1_valid & r_p1_ctl.emit) + IW'(r_p2_valid);
    assign credit   = (inflight < IW'(OUT_DEPTH));

    always_comb begin
        n_state  = r_state;
        n_j      = r_j;
        n_final  = r_final;
        op_valid = 1'b0;
        op_kind  = nss_pkg::OP_ZERO;
        op_col   = '0;
        op_ctl   = '0;
        o_q_pop  = 1'b0;
        case (r_state)
            nss_pkg::SEQ_ITEM: begin
                if (!i_q_empty && (!i_q_flags.emit || credit)) begin
                    op_valid     = 1'b1;
                    op_kind      = nss_pkg::OP_CELL;
                    op_col       = i_q_col;
                    op_ctl.up_v  = i_q_flags.up_v;
                    op_ctl.mid_v = i_q_flags.mid_v;
                    op_ctl.clear = (i_q_col == '0);
                    op_ctl.emit  = i_q_flags.emit;
                    op_ctl.last  = i_q_flags.emit && !i_q_flags.extra;
                    o_q_pop      = 1'b1;
                    n_final      = i_q_flags.is_final;
                    if (i_q_flags.extra) begin
                        n_state = nss_pkg::SEQ_EXTRA;
                    end
                end
            end
            nss_pkg::SEQ_EXTRA: begin
                // A zero column past the right edge completes the cell above.
                if (credit) begin
                    op_valid    = 1'b1;
                    op_kind     = nss_pkg::OP_ZERO;
                    op_ctl.emit = 1'b1;
                    op_ctl.last = !r_final;
                    if (r_final) begin
                        n_state = nss_pkg::SEQ_FLUSH;
                        n_j     = '0;
                    end else begin
                        n_state = nss_pkg::SEQ_ITEM;
                    end
                end
            end
            nss_pkg::SEQ_FLUSH: begin
                if (r_j == '0 || credit) begin
                    op_valid     = 1'b1;
                    op_kind      = nss_pkg::OP_FLUSH;
                    op_col       = r_j;
                    op_ctl.clear = (r_j == '0);
                    op_ctl.emit  = (r_j != '0);
                    if (r_j == i_last) begin
                        n_state = nss_pkg::SEQ_TAIL;
                    end else begin
                        n_j = r_j + 1'b1;
                    end
                end
            end
            nss_pkg::SEQ_TAIL: begin
                if (credit) begin
                    op_valid    = 1'b1;
                    op_kind     = nss_pkg::OP_ZERO;
                    op_ctl.emit = 1'b1;
                    op_ctl.last = 1'b1;
                    op_ctl.eog  = 1'b1;
                    n_state     = nss_pkg::SEQ_ITEM;
                end
            end
            default: begin
                n_state = nss_pkg::SEQ_ITEM;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= nss_pkg::SEQ_ITEM;
            r_j        <= '0;
            r_final    <= 1'b0;
            r_p1_valid <= 1'b0;
            r_p2_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_j        <= n_j;
            r_final    <= n_final;
            r_p1_valid <= op_valid;
            r_p2_valid <= r_p1_valid && r_p1_ctl.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p1_kind <= op_kind;
        r_p1_col  <= op_col;
        r_p1_cell <= i_q_cell;
        r_p1_ctl  <= op_ctl;
        r_p2_last <= r_p1_ctl.last;
        r_p2_eog  <= r_p1_ctl.eog;
        r_rd      <= r_line[op_col];
    end

    assign rd_older = r_rd[2*CELL_BITS-1:CELL_BITS];
    assign rd_newer = r_rd[CELL_BITS-1:0];

    always_ff @(posedge i_clk) begin
        if (r_p1_valid && r_p1_kind == nss_pkg::OP_CELL) begin
            r_line[r_p1_col] <= {rd_newer, r_p1_cell};
        end
    end

    // Rows that do not belong to the current grid read as zero.
    always_comb begin
        case (r_p1_kind)
            nss_pkg::OP_CELL: begin
                col_u = r_p1_ctl.up_v  ? rd_older : '0;
                col_m = r_p1_ctl.mid_v ? rd_newer : '0;
                col_l = r_p1_cell;
            end
            nss_pkg::OP_FLUSH: begin
                col_u = rd_older;
                col_m = rd_newer;
                col_l = '0;
            end
            default: begin
                col_u = '0;
                col_m = '0;
                col_l = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (r_p1_valid) begin
            if (r_p1_ctl.clear) begin
                r_wu[0] <= '0;
                r_wm[0] <= '0;
                r_wl[0] <= '0;
                r_wu[1] <= '0;
                r_wm[1] <= '0;
                r_wl[1] <= '0;
            end else begin
                r_wu[0] <= r_wu[1];
                r_wm[0] <= r_wm[1];
                r_wl[0] <= r_wl[1];
                r_wu[1] <= r_wu[2];
                r_wm[1] <= r_wm[2];
                r_wl[1] <= r_wl[2];
            end
            r_wu[2] <= col_u;
            r_wm[2] <= col_m;
            r_wl[2] <= col_l;
        end
    end

    assign acc = ACC_W'(r_wu[0]) + ACC_W'(r_wu[1]) + ACC_W'(r_wu[2])
               + ACC_W'(r_wm[0]) + ACC_W'(r_wm[2])
               + ACC_W'(r_wl[0]) + ACC_W'(r_wl[1]) + ACC_W'(r_wl[2]);

    assign o_push               = r_p2_valid;
    assign o_result.sum         = acc[nss_pkg::SUM_W-1:0];
    assign o_result.last_of_run = r_p2_last;
    assign o_result.end_of_grid = r_p2_eog;

endmodule

FILE: rtl/neighbour_sum_3x3_unit.sv
// Top level of the 3x3 neighbour sum unit: configuration register, front end,
// work queue, back end and result buffer. Depends on nss_pkg and all nss_ modules.
`timescale 1ns / 1ps

// Usage:
// Cells of a square grid enter in raster order on the input channel
// (i_in_valid / o_in_stall, beat = one cell). For each cell the unit returns
// the sum of its eight neighbours, cells outside the grid counting as zero, on
// the output channel (o_out_valid / i_out_stall). A sum leaves once the cell's
// lower-right neighbour has arrived; the final cell of the grid also flushes
// the whole last row and marks its last sum with o_end_of_grid. o_last_of_run
// flags the last sum caused by an input beat.
// grid_size is written through the APB port at address 0 (clamped to
// 2..MAX_GRID); a write restarts the grid at row 0, column 0.
// A beat passes the work queue, back-end registers and result buffer.
// Throughput: one cell per cycle while the queue has room; a cell closing a row
// from the second row on costs the back end an extra zero column, and the final
// cell flushes the last row from the line memory, one column per cycle while the
// result buffer has room. A 4-beat queue absorbs this, after which o_in_stall
// rises. When the receiver stalls, up to 4 sums wait in the result buffer and the
// back end then stops; the queue keeps taking cells until it fills.
// Reset: grid_size returns to 32 and the position to row 0, column 0. The line
// memory is not cleared; rows not yet written in a grid are masked out.

module neighbour_sum_3x3_unit #(
    parameter int MAX_GRID  = nss_pkg::MAX_GRID_DEF,
    parameter int CELL_BITS = nss_pkg::CELL_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [CELL_BITS-1:0]           i_cell_value,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [nss_pkg::SUM_W-1:0]      o_neighbour_sum,
    output logic                           o_last_of_run,
    output logic                           o_end_of_grid,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [nss_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [nss_pkg::APB_DATA_W-1:0] pwdata,
    output logic [nss_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready
);

    localparam int COL_W  = $clog2(MAX_GRID);
    localparam int GW     = nss_pkg::GRID_W;
    localparam int Q_W    = $bits(nss_pkg::t_item_flags) + COL_W + CELL_BITS;
    localparam int R_W    = $bits(nss_pkg::t_result);
    localparam int OCW    = $clog2(nss_pkg::OUT_DEPTH + 1);
    localparam logic [GW-1:0] MAX_G = GW'(MAX_GRID);

    logic [GW-1:0]        r_grid_size;
    logic                 cfg_write;
    logic                 grid_write;
    logic [GW-1:0]        last_full;
    logic [COL_W-1:0]     grid_last;

    logic                 f_push;
    logic [COL_W-1:0]     f_col;
    nss_pkg::t_item_flags f_flags;

    logic [Q_W-1:0]       q_wdata;
    logic [Q_W-1:0]       q_rdata;
    logic                 q_empty;
    logic                 q_full;
    logic                 q_pop;
    nss_pkg::t_item_flags q_flags;
    logic [COL_W-1:0]     q_col;
    logic [CELL_BITS-1:0] q_cell;

    logic                 b_push;
    nss_pkg::t_result     b_result;

    logic [R_W-1:0]       o_rdata;
    logic                 o_empty;
    logic                 o_full;
    logic [OCW-1:0]       o_count;
    nss_pkg::t_result     head;

    assign pready     = 1'b1;
    assign cfg_write  = psel && penable && pwrite;
    assign grid_write = cfg_write && (paddr[2] == nss_pkg::REG_GRID_SIZE);
    assign prdata     = (paddr[2] == nss_pkg::REG_GRID_SIZE) ?
                        nss_pkg::APB_DATA_W'(r_grid_size) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_size <= nss_pkg::GRID_RESET;
        end else if (grid_write) begin
            r_grid_size <= pwdata[GW-1:0];
        end
    end

    always_comb begin
        if (r_grid_size < GW'(2)) begin
            last_full = GW'(1);
        end else if (r_grid_size > MAX_G) begin
            last_full = MAX_G - GW'(1);
        end else begin
            last_full = r_grid_size - GW'(1);
        end
    end
    assign grid_last = last_full[COL_W-1:0];

    nss_front #(
        .MAX_GRID (MAX_GRID)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_in_valid),
        .i_queue_full (q_full),
        .i_restart    (grid_write),
        .i_last       (grid_last),
        .o_stall      (o_in_stall),
        .o_push       (f_push),
        .o_col        (f_col),
        .o_flags      (f_flags)
    );

    assign q_wdata = {f_flags, f_col, i_cell_value};

    nss_fifo #(
        .WIDTH (Q_W),
        .DEPTH (nss_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_data  (q_wdata),
        .i_pop   (q_pop),
        .o_data  (q_rdata),
        .o_empty (q_empty),
        .o_full  (q_full),
        .o_count ()
    );

    assign {q_flags, q_col, q_cell} = q_rdata;

    nss_back #(
        .MAX_GRID  (MAX_GRID),
        .CELL_BITS (CELL_BITS),
        .OUT_DEPTH (nss_pkg::OUT_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (q_empty),
        .i_q_cell    (q_cell),
        .i_q_col     (q_col),
        .i_q_flags   (q_flags),
        .o_q_pop     (q_pop),
        .i_last      (grid_last),
        .i_out_count (o_count),
        .o_push      (b_push),
        .o_result    (b_result)
    );

    nss_fifo #(
        .WIDTH (R_W),
        .DEPTH (nss_pkg::OUT_DEPTH)
    ) u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (b_push),
        .i_data  (b_result),
        .i_pop   (o_out_valid && !i_out_stall),
        .o_data  (o_rdata),
        .o_empty (o_empty),
        .o_full  (o_full),
        .o_count (o_count)
    );

    assign head            = o_rdata;
    assign o_out_valid     = !o_empty;
    assign o_neighbour_sum = head.sum;
    assign o_last_of_run   = head.last_of_run;
    assign o_end_of_grid   = head.end_of_grid;

`ifndef SYNTHESIS
    // The back end's credit check must keep the result buffer from overflowing.
    a_no_result_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        b_push |-> !o_full)
        else $error("result pushed into a full buffer");

    a_no_queue_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_empty)
        else $error("work queue popped while empty");

    // The grid's final sum is always the last one of its run.
    a_eog_closes_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_end_of_grid) |-> o_last_of_run)
        else $error("end of grid without end of run");
`endif

endmodule
